// ===== rtl/core/tgp_pkg.sv =====
// shared types and constants for the turtle grid plotter
`default_nettype none
package tgp_pkg;

  localparam int CMD_W  = 3;
  localparam int CNT_W  = 8;
  localparam int POS_W  = 6;
  localparam int ROW_W  = 64;
  localparam int HEAD_W = 2;

  localparam int IN_W  = 24;
  localparam int OUT_W = 80;

  // input beat layout
  localparam int IN_CMD_LO = 0;
  localparam int IN_CNT_LO = IN_CMD_LO + CMD_W;
  localparam int IN_ROW_LO = IN_CNT_LO + CNT_W;

  // output beat layout
  localparam int OUT_BITS_LO = 0;
  localparam int OUT_PROW_LO = OUT_BITS_LO + ROW_W;
  localparam int OUT_PCOL_LO = OUT_PROW_LO + POS_W;
  localparam int OUT_HEAD_LO = OUT_PCOL_LO + POS_W;
  localparam int OUT_PEN_BIT = OUT_HEAD_LO + HEAD_W;
  localparam int OUT_EDGE_BIT = OUT_PEN_BIT + 1;

  localparam logic [CMD_W-1:0] CMD_PEN_UP   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PEN_DOWN = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RIGHT    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_LEFT     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_MOVE     = 3'd4;
  localparam logic [CMD_W-1:0] CMD_READ     = 3'd5;

  localparam logic [HEAD_W-1:0] HEAD_EAST  = 2'd0;
  localparam logic [HEAD_W-1:0] HEAD_SOUTH = 2'd1;
  localparam logic [HEAD_W-1:0] HEAD_WEST  = 2'd2;
  localparam logic [HEAD_W-1:0] HEAD_NORTH = 2'd3;

  typedef struct packed {
    logic             en;
    logic [POS_W-1:0] addr;
    logic [ROW_W-1:0] data;
  } wr_t;

endpackage
`default_nettype wire

// ===== rtl/core/tgp_grid.sv =====
// grid row memory with per-row valid bits and registered read
`default_nettype none
module tgp_grid
  import tgp_pkg::*;
#(
  parameter int GRID_SIZE = 64
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [POS_W-1:0] raddr,
  output logic      [ROW_W-1:0] rdata,
  input  wire wr_t              wr
);

  localparam int AW = $clog2(GRID_SIZE);

  logic [ROW_W-1:0]     mem [GRID_SIZE];
  logic [GRID_SIZE-1:0] valid;
  logic [ROW_W-1:0]     q;
  logic                 q_valid;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr[AW-1:0]] <= wr.data;
    end
    q <= mem[raddr[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      q_valid <= 1'b0;
    end else begin
      q_valid <= valid[raddr[AW-1:0]];
      if (wr.en) begin
        valid[wr.addr[AW-1:0]] <= 1'b1;
      end
    end
  end

  // a row never written reads as cleared
  assign rdata = q_valid ? q : '0;

endmodule
`default_nettype wire

// ===== rtl/core/turtle_grid_plotter_unit.sv =====
// top level of the turtle grid plotter
//
//  channel | dir | beat fields (lsb first)
//  s_axis  | in  | cmd[2:0] step_count[10:3] row_index[16:11], pad to 24
//  m_axis  | out | row_bits[63:0] pos_row[69:64] pos_col[75:70]
//          |     | heading_out[77:76] pen_is_up[78] hit_edge[79]
//
// pen, turn and unused commands: go straight from accept to the finish state and the result
// read row: an extra read state covers the registered row memory read
// move of n cells: the move state steps one cell per cycle, stopping early when clamped at the
// border; each cell is marked through a read-modify-write pipeline on the row memory,
// forwarded on the same row
// reset clears position, heading and pen; row valid bits clear the grid
// one command at a time; a finished result waits in the output register
`default_nettype none
module turtle_grid_plotter_unit
  import tgp_pkg::*;
#(
  parameter int GRID_SIZE = 64
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire logic [IN_W-1:0]  s_axis_tdata,  // cmd, step_count, row_index
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output logic      [OUT_W-1:0] m_axis_tdata   // row_bits, pos_row, pos_col, heading, pen, edge
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_MOVE   = 2'd1;
  localparam logic [1:0] ST_READ   = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  localparam logic [POS_W-1:0] LAST = POS_W'(GRID_SIZE - 1);

  logic [1:0]        state;
  logic [POS_W-1:0]  turtle_row;
  logic [POS_W-1:0]  turtle_col;
  logic [HEAD_W-1:0] heading;
  logic              pen_raised;
  logic [CNT_W-1:0]  cnt;
  logic              row_oob;
  logic [ROW_W-1:0]  res_bits;
  logic              res_edge;

  logic             b_valid;
  logic [POS_W-1:0] b_row;
  logic [POS_W-1:0] b_col;
  logic             last_en;
  logic [POS_W-1:0] last_row;
  logic [ROW_W-1:0] last_data;

  logic [CMD_W-1:0] in_cmd;
  logic [CNT_W-1:0] in_cnt;
  logic [POS_W-1:0] in_row;
  logic             accept;
  logic             out_free;

  logic             blocked;
  logic [POS_W-1:0] next_row;
  logic [POS_W-1:0] next_col;
  logic [POS_W-1:0] raddr;
  logic [ROW_W-1:0] rdata;
  logic [ROW_W-1:0] base_row;
  wr_t              wr;

  assign in_cmd   = s_axis_tdata[IN_CMD_LO +: CMD_W];
  assign in_cnt   = s_axis_tdata[IN_CNT_LO +: CNT_W];
  assign in_row   = s_axis_tdata[IN_ROW_LO +: POS_W];
  assign s_axis_tready = (state == ST_IDLE);
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    blocked  = 1'b0;
    next_row = turtle_row;
    next_col = turtle_col;
    case (heading)
      HEAD_EAST: begin
        blocked  = (turtle_col >= LAST);
        next_col = turtle_col + POS_W'(1);
      end
      HEAD_SOUTH: begin
        blocked  = (turtle_row >= LAST);
        next_row = turtle_row + POS_W'(1);
      end
      HEAD_WEST: begin
        blocked  = (turtle_col == '0);
        next_col = turtle_col - POS_W'(1);
      end
      HEAD_NORTH: begin
        blocked  = (turtle_row == '0);
        next_row = turtle_row - POS_W'(1);
      end
      default: blocked = 1'b1;
    endcase
  end

  assign raddr = (state == ST_MOVE) ? next_row : in_row;

  // forward the row written in the previous cycle
  assign base_row = (last_en && last_row == b_row) ? last_data : rdata;

  always_comb begin
    wr.en   = b_valid;
    wr.addr = b_row;
    wr.data = base_row | (ROW_W'(1) << b_col);
  end

  tgp_grid #(
    .GRID_SIZE(GRID_SIZE)
  ) u_grid (
    .clk  (clk),
    .rst  (rst),
    .raddr(raddr),
    .rdata(rdata),
    .wr   (wr)
  );

  always_ff @(posedge clk) begin
    last_row  <= wr.addr;
    last_data <= wr.data;
    if (state == ST_MOVE) begin
      b_row <= next_row;
      b_col <= next_col;
    end
    if (accept) begin
      cnt      <= in_cnt;
      row_oob  <= (32'(in_row) >= GRID_SIZE);
      res_bits <= '0;
      res_edge <= 1'b0;
    end else if (state == ST_MOVE) begin
      cnt <= cnt - CNT_W'(1);
      if (blocked) begin
        res_edge <= 1'b1;
      end
    end else if (state == ST_READ) begin
      res_bits <= row_oob ? '0 : rdata;
    end
    if (state == ST_FINISH && out_free) begin
      m_axis_tdata[OUT_BITS_LO +: ROW_W]  <= res_bits;
      m_axis_tdata[OUT_PROW_LO +: POS_W]  <= turtle_row;
      m_axis_tdata[OUT_PCOL_LO +: POS_W]  <= turtle_col;
      m_axis_tdata[OUT_HEAD_LO +: HEAD_W] <= heading;
      m_axis_tdata[OUT_PEN_BIT]           <= pen_raised;
      m_axis_tdata[OUT_EDGE_BIT]          <= res_edge;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      turtle_row    <= '0;
      turtle_col    <= '0;
      heading       <= HEAD_EAST;
      pen_raised    <= 1'b0;
      b_valid       <= 1'b0;
      last_en       <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      last_en <= b_valid;
      b_valid <= 1'b0;
      if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_FINISH;
            case (in_cmd)
              CMD_PEN_UP:   pen_raised <= 1'b1;
              CMD_PEN_DOWN: pen_raised <= 1'b0;
              CMD_RIGHT:    heading <= heading + HEAD_W'(1);
              CMD_LEFT:     heading <= heading - HEAD_W'(1);
              CMD_MOVE: begin
                if (in_cnt != '0) begin
                  state <= ST_MOVE;
                end
              end
              CMD_READ:     state <= ST_READ;
              default:      state <= ST_FINISH;
            endcase
          end
        end
        ST_MOVE: begin
          if (blocked) begin
            state <= ST_FINISH;
          end else begin
            turtle_row <= next_row;
            turtle_col <= next_col;
            b_valid    <= !pen_raised;
            if (cnt == CNT_W'(1)) begin
              state <= ST_FINISH;
            end
          end
        end
        ST_READ: state <= ST_FINISH;
        ST_FINISH: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/tgp_checker.sv =====
// port-level checks for the turtle grid plotter, bound to the top level
`default_nettype none
module tgp_checker
  import tgp_pkg::*;
#(
  parameter int GRID_SIZE = 64
) (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             s_axis_tvalid,
  input wire logic             s_axis_tready,
  input wire logic [IN_W-1:0]  s_axis_tdata,
  input wire logic             m_axis_tvalid,
  input wire logic             m_axis_tready,
  input wire logic [OUT_W-1:0] m_axis_tdata
);

  localparam logic [POS_W-1:0] LAST = POS_W'(GRID_SIZE - 1);

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while a command is in progress");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata))
    else $error("waiting input beat changed");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result beat changed");

  a_edge_no_bits: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[OUT_EDGE_BIT] |-> m_axis_tdata[OUT_BITS_LO +: ROW_W] == '0)
    else $error("clamped move carries row bits");

  a_pos_in_grid: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[OUT_PROW_LO +: POS_W] <= LAST &&
                      m_axis_tdata[OUT_PCOL_LO +: POS_W] <= LAST)
    else $error("turtle position outside the grid");

endmodule

bind turtle_grid_plotter_unit tgp_checker #(
  .GRID_SIZE(GRID_SIZE)
) u_tgp_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tdata (s_axis_tdata),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// self-checking stream testbench for the turtle grid plotter unit
`default_nettype none
module testbench;
  import tgp_pkg::*;

  localparam int GRID_SIZE = 64;
  localparam int RANDOM_CMDS = 1950;
  localparam int DRAIN_CYCLES = 80;

  localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [POS_W-1:0] row_index;
    logic [CNT_W-1:0] step_count;
    logic [CMD_W-1:0] cmd;
  } plot_cmd_t;

  typedef struct packed {
    logic              hit_edge;
    logic              pen_is_up;
    logic [HEAD_W-1:0] heading;
    logic [POS_W-1:0]  pos_col;
    logic [POS_W-1:0]  pos_row;
    logic [ROW_W-1:0]  row_bits;
  } plot_result_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;

  turtle_grid_plotter_unit #(
    .GRID_SIZE(GRID_SIZE)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow plotter state
  logic [ROW_W-1:0]  shadow_grid [0:GRID_SIZE-1];
  logic [POS_W-1:0]  shadow_row = '0;
  logic [POS_W-1:0]  shadow_col = '0;
  logic [HEAD_W-1:0] shadow_heading = HEAD_EAST;
  logic              shadow_pen_up = 1'b0;

  plot_cmd_t    cmds_pending [$];
  plot_result_t plots_expected [$];
  int           cmds_queued = 0;
  int           cmds_accepted = 0;
  int           mismatches = 0;
  logic         beat_taken = 1'b0;
  int           gap_left = 0;
  int           burst_left = 0;
  int           run_left = 0;

  initial begin
    for (int r = 0; r < GRID_SIZE; r++) shadow_grid[r] = '0;
  end

  function automatic plot_result_t plot_step(input plot_cmd_t c);
    plot_result_t res;
    logic         blocked;
    int           i;
    res = '0;
    blocked = 1'b0;
    case (c.cmd)
      CMD_PEN_UP:   shadow_pen_up = 1'b1;
      CMD_PEN_DOWN: shadow_pen_up = 1'b0;
      CMD_RIGHT:    shadow_heading = shadow_heading + 2'd1;
      CMD_LEFT:     shadow_heading = shadow_heading - 2'd1;
      CMD_MOVE: begin
        for (i = 0; i < int'(c.step_count) && !blocked; i++) begin
          case (shadow_heading)
            HEAD_EAST: begin
              if (shadow_col >= GRID_SIZE - 1) blocked = 1'b1;
              else shadow_col = shadow_col + 1'b1;
            end
            HEAD_SOUTH: begin
              if (shadow_row >= GRID_SIZE - 1) blocked = 1'b1;
              else shadow_row = shadow_row + 1'b1;
            end
            HEAD_WEST: begin
              if (shadow_col == 0) blocked = 1'b1;
              else shadow_col = shadow_col - 1'b1;
            end
            default: begin
              if (shadow_row == 0) blocked = 1'b1;
              else shadow_row = shadow_row - 1'b1;
            end
          endcase
          if (!blocked && !shadow_pen_up)
            shadow_grid[shadow_row][shadow_col] = 1'b1;
        end
        res.hit_edge = blocked;
      end
      CMD_READ: begin
        if (c.row_index < GRID_SIZE)
          res.row_bits = shadow_grid[c.row_index] &
                         ((GRID_SIZE >= 64) ? {ROW_W{1'b1}} : ((64'd1 << GRID_SIZE) - 64'd1));
      end
      default: ;
    endcase
    res.pos_row = shadow_row;
    res.pos_col = shadow_col;
    res.heading = shadow_heading;
    res.pen_is_up = shadow_pen_up;
    return res;
  endfunction

  task automatic report_mismatch(input string field, input logic [ROW_W-1:0] got,
                                 input logic [ROW_W-1:0] want);
    mismatches++;
    $display("[%0t] mismatch on %s: got %h, expected %h", $time, field, got, want);
  endtask

  task automatic queue_cmd(input logic [CMD_W-1:0] cmd, input logic [CNT_W-1:0] cnt,
                           input logic [POS_W-1:0] row_sel);
    plot_cmd_t c;
    c.cmd = cmd;
    c.step_count = cnt;
    c.row_index = row_sel;
    cmds_pending.push_back(c);
    cmds_queued++;
  endtask

  // sender: bursts of beats with random gaps in between
  always @(negedge clk) begin
    plot_cmd_t c;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || beat_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (cmds_pending.size() > 0) begin
        c = cmds_pending.pop_front();
        s_axis_tdata <= {{(IN_W - $bits(plot_cmd_t)){1'b0}}, c};
        s_axis_tvalid <= 1'b1;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver: alternating ready and stall runs, some stalls skipped
  always @(negedge clk) begin
    int stall;
    if (rst) begin
      m_axis_tready <= 1'b0;
      run_left = 0;
    end else if (run_left > 0) begin
      run_left--;
    end else if (m_axis_tready) begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (stall == 0) begin
        run_left = $urandom_range(1, 40);
      end else begin
        m_axis_tready <= 1'b0;
        run_left = stall;
      end
    end else begin
      m_axis_tready <= 1'b1;
      run_left = $urandom_range(1, 40);
    end
  end

  // monitor: predict on accepted commands, check returned beats
  always @(posedge clk) begin
    plot_result_t got;
    plot_result_t want;
    if (rst) begin
      beat_taken <= 1'b0;
    end else begin
      beat_taken <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        plots_expected.push_back(plot_step(plot_cmd_t'(s_axis_tdata[$bits(plot_cmd_t)-1:0])));
        cmds_accepted++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = plot_result_t'(m_axis_tdata);
        if (plots_expected.size() == 0) begin
          report_mismatch("unexpected beat", got.row_bits, '0);
        end else begin
          want = plots_expected.pop_front();
          if (got.row_bits !== want.row_bits)
            report_mismatch("row_bits", got.row_bits, want.row_bits);
          if (got.pos_row !== want.pos_row)
            report_mismatch("pos_row", 64'(got.pos_row), 64'(want.pos_row));
          if (got.pos_col !== want.pos_col)
            report_mismatch("pos_col", 64'(got.pos_col), 64'(want.pos_col));
          if (got.heading !== want.heading)
            report_mismatch("heading_out", 64'(got.heading), 64'(want.heading));
          if (got.pen_is_up !== want.pen_is_up)
            report_mismatch("pen_is_up", 64'(got.pen_is_up), 64'(want.pen_is_up));
          if (got.hit_edge !== want.hit_edge)
            report_mismatch("hit_edge", 64'(got.hit_edge), 64'(want.hit_edge));
        end
      end
    end
  end

  initial begin
    int pick;
    logic [CNT_W-1:0] cnt;
    logic [POS_W-1:0] sel;
    // corner walk around the border
    queue_cmd(CMD_READ, 8'd0, 6'd0);
    queue_cmd(CMD_MOVE, 8'd255, 6'd0);
    queue_cmd(CMD_READ, 8'd0, 6'd0);
    queue_cmd(CMD_RIGHT, 8'd0, 6'd0);
    queue_cmd(CMD_MOVE, 8'd0, 6'd0);
    queue_cmd(CMD_MOVE, 8'd63, 6'd0);
    queue_cmd(CMD_MOVE, 8'd1, 6'd0);
    queue_cmd(CMD_READ, 8'd0, 6'd63);
    repeat (4) queue_cmd(CMD_LEFT, 8'd0, 6'd0);
    repeat (3) queue_cmd(CMD_RIGHT, 8'd0, 6'd0);
    queue_cmd(CMD_RIGHT, 8'd0, 6'd0);
    queue_cmd(CMD_RIGHT, 8'd0, 6'd0);
    queue_cmd(CMD_PEN_UP, 8'd255, 6'd63);
    queue_cmd(CMD_MOVE, 8'd255, 6'd0);
    queue_cmd(CMD_READ, 8'd0, 6'd63);
    queue_cmd(CMD_PEN_DOWN, 8'd0, 6'd0);
    queue_cmd(CMD_RIGHT, 8'd0, 6'd0);
    queue_cmd(CMD_MOVE, 8'd255, 6'd0);
    queue_cmd(CMD_READ, 8'd255, 6'd0);
    queue_cmd(CMD_SPARE_6, 8'd255, 6'd63);
    queue_cmd(CMD_SPARE_7, 8'd0, 6'd31);

    for (int n = 0; n < RANDOM_CMDS; n++) begin
      pick = $urandom_range(0, 99);
      cnt = CNT_W'($urandom_range(0, 255));
      sel = POS_W'($urandom_range(0, 63));
      if (pick < 35) begin
        if ($urandom_range(0, 9) != 0) cnt = CNT_W'($urandom_range(0, 15));
        queue_cmd(CMD_MOVE, cnt, sel);
      end else if (pick < 55) begin
        queue_cmd(CMD_READ, cnt, sel);
      end else if (pick < 70) begin
        queue_cmd(CMD_RIGHT, cnt, sel);
      end else if (pick < 80) begin
        queue_cmd(CMD_LEFT, cnt, sel);
      end else if (pick < 87) begin
        queue_cmd(CMD_PEN_DOWN, cnt, sel);
      end else if (pick < 94) begin
        queue_cmd(CMD_PEN_UP, cnt, sel);
      end else begin
        queue_cmd($urandom_range(0, 1) ? CMD_SPARE_7 : CMD_SPARE_6, cnt, sel);
      end
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    do @(posedge clk);
    while (cmds_pending.size() > 0 || cmds_accepted < cmds_queued || plots_expected.size() > 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
`default_nettype wire
